// ===== src/ctrf_pkg.sv =====
// Shared types and constants of the contact trace request forwarding block.
package ctrf_pkg;

  localparam int NodeW   = 6;
  localparam int DistW   = 16;
  localparam int TimeW   = 32;
  localparam int CfgIdxW = 2;

  // All ones marks a node with no known path to a data holder.
  localparam logic [DistW-1:0] DistUnreach = '1;

  typedef enum logic [1:0] {
    OpFlags   = 2'd0,
    OpDist    = 2'd1,
    OpStart   = 2'd2,
    OpContact = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusNone     = 2'd0,
    StatusReached  = 2'd1,
    StatusRejected = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgForwardMode = 2'd0,
    CfgWindowStart = 2'd1,
    CfgWindowEnd   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ModeEpidemic = 1'b0,
    ModeGreedy   = 1'b1
  } mode_e;

  typedef struct packed {
    op_e              op;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic             has_data;
    logic             is_off;
    logic [DistW-1:0] distance;
    logic [TimeW-1:0] contact_time;
  } in_item_t;

endpackage

// ===== src/ctrf_in_if.sv =====
// Input channel of the forwarding block: one trace event per transfer.
interface ctrf_in_if import ctrf_pkg::*;;
  logic             valid;
  logic             ready;
  op_e              op;
  logic [NodeW-1:0] node_a;
  logic [NodeW-1:0] node_b;
  logic             has_data;
  logic             is_off;
  logic [DistW-1:0] distance;
  logic [TimeW-1:0] contact_time;

  modport source (
    output valid, op, node_a, node_b, has_data, is_off, distance, contact_time,
    input  ready
  );

  modport sink (
    input  valid, op, node_a, node_b, has_data, is_off, distance, contact_time,
    output ready
  );
endinterface

// ===== src/ctrf_out_if.sv =====
// Output channel of the forwarding block: one result per transfer.
interface ctrf_out_if import ctrf_pkg::*;;
  logic             valid;
  logic             ready;
  status_e          status;
  logic [TimeW-1:0] latency;

  modport source (
    output valid, status, latency,
    input  ready
  );

  modport sink (
    input  valid, status, latency,
    output ready
  );
endinterface

// ===== src/contact_trace_request_forwarding_core.sv =====
// Top level of the contact trace request forwarding block.
//
// The block replays a trace of pairwise node contacts and tracks how a data
// request spreads: node flag events and distance entries build the per-node
// state, a start event places the request at a node, and contact events move
// it, either by epidemic flooding or by greedy handover to a strictly nearer
// node. Every input transfer yields exactly one result transfer, and a new
// event is taken in every cycle while the consumer is ready, so the sustained
// rate is one event per clock. The accepting edge loads the input register
// together with the registered read of the nearest-distance RAM; the compute
// stage then evaluates both contact directions and loads the result register,
// which offers the result. That result register decouples the two sides, so
// a stalled consumer only stops the input once the compute stage is also
// occupied. Distance entries written by one event are forwarded to the event
// right behind it. The distance RAM carries one valid flag per node, cleared
// by reset, so there is no clearing pass after reset. Configuration must
// only be written while no event is in flight.
module contact_trace_request_forwarding_core import ctrf_pkg::*; #(
  parameter int NODES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ctrf_in_if.sink            in_ch,
  ctrf_out_if.source         out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  localparam int IdxW = $clog2(NODES);

  // Configuration registers.
  mode_e            mode_q;
  logic [TimeW-1:0] win_start_q;
  logic [TimeW-1:0] win_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeEpidemic;
      win_start_q <= '0;
      win_end_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgForwardMode: mode_q      <= mode_e'(cfg_wdata_i[0]);
        CfgWindowStart: win_start_q <= cfg_wdata_i;
        CfgWindowEnd:   win_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic     accept;
  logic     fire;
  logic     stg_vld_q;
  in_item_t item_q;
  logic     out_vld_q;

  assign fire         = stg_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !stg_vld_q || fire;
  assign accept       = in_ch.valid && in_ch.ready;

  // Per-node state held in flip-flops.
  logic [NODES-1:0] hd_q, hd_d;
  logic [NODES-1:0] off_q, off_d;
  logic [NODES-1:0] rm_q, rm_d;
  logic [NODES-1:0] nd_vld_q, nd_vld_d;
  logic [IdxW-1:0]  holder_q, holder_d;
  logic             running_q, running_d;

  // Nearest-distance store with forwarding of the write that lands on the
  // same edge as the read of the following event.
  logic             nd_we;
  logic [IdxW-1:0]  in_a_idx, in_b_idx;
  logic [DistW-1:0] rd_a, rd_b;
  logic             byp_a_q, byp_b_q;
  logic [DistW-1:0] byp_dist_q;

  logic [IdxW-1:0]  a_idx, b_idx;

  assign in_a_idx = IdxW'(in_ch.node_a);
  assign in_b_idx = IdxW'(in_ch.node_b);
  assign a_idx    = IdxW'(item_q.node_a);
  assign b_idx    = IdxW'(item_q.node_b);

  ctrf_ram #(
    .Width (DistW),
    .Depth (NODES)
  ) u_dist_ram (
    .clk_i     (clk_i),
    .we_i      (nd_we),
    .waddr_i   (a_idx),
    .wdata_i   (item_q.distance),
    .re_i      (accept),
    .raddr_a_i (in_a_idx),
    .raddr_b_i (in_b_idx),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      byp_a_q   <= 1'b0;
      byp_b_q   <= 1'b0;
    end else begin
      if (accept) begin
        stg_vld_q <= 1'b1;
        byp_a_q   <= nd_we && (in_a_idx == a_idx);
        byp_b_q   <= nd_we && (in_b_idx == a_idx);
      end else if (fire) begin
        stg_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op           <= in_ch.op;
      item_q.node_a       <= in_ch.node_a;
      item_q.node_b       <= in_ch.node_b;
      item_q.has_data     <= in_ch.has_data;
      item_q.is_off       <= in_ch.is_off;
      item_q.distance     <= in_ch.distance;
      item_q.contact_time <= in_ch.contact_time;
      byp_dist_q          <= item_q.distance;
    end
  end

  // Event evaluation.
  logic             a_ok, b_ok;
  logic             hd_a, hd_b, off_a, off_b, rm_a, rm_b;
  logic [DistW-1:0] nd_a, nd_b;
  logic             in_win, ct_go, link;
  logic             e_en1, e_hit1, e_en2, e_hit2;
  logic             g_en1, g_hit1, g_en2, g_hit2;
  logic             a_nearer, b_nearer;
  logic [IdxW-1:0]  g_h1, g_h2;
  status_e          res_status;
  logic [TimeW-1:0] res_lat;

  always_comb begin
    a_ok  = 32'(item_q.node_a) < NODES;
    b_ok  = 32'(item_q.node_b) < NODES;
    hd_a  = hd_q[a_idx];
    hd_b  = hd_q[b_idx];
    off_a = off_q[a_idx];
    off_b = off_q[b_idx];
    rm_a  = rm_q[a_idx];
    rm_b  = rm_q[b_idx];
    nd_a  = byp_a_q ? byp_dist_q : (nd_vld_q[a_idx] ? rd_a : DistUnreach);
    nd_b  = byp_b_q ? byp_dist_q : (nd_vld_q[b_idx] ? rd_b : DistUnreach);

    in_win = (item_q.contact_time >= win_start_q) && (item_q.contact_time < win_end_q);
    ct_go  = running_q && a_ok && b_ok && in_win;
    link   = !off_a && !off_b;

    // Epidemic: node_b passes to node_a first, then node_a to node_b.
    e_en1  = link && rm_b;
    e_hit1 = e_en1 && hd_a;
    e_en2  = link && (rm_a || e_en1);
    e_hit2 = e_en2 && hd_b;

    // Greedy: the holder moves only to a strictly nearer neighbor.
    a_nearer = nd_a < nd_b;
    b_nearer = nd_b < nd_a;
    g_en1    = link && (holder_q == b_idx);
    g_h1     = g_en1 ? (a_nearer ? a_idx : b_idx) : holder_q;
    g_hit1   = g_en1 && (a_nearer ? hd_a : hd_b);
    g_en2    = link && (g_h1 == a_idx);
    g_h2     = b_nearer ? b_idx : a_idx;
    g_hit2   = g_en2 && (b_nearer ? hd_b : hd_a);

    hd_d       = hd_q;
    off_d      = off_q;
    rm_d       = rm_q;
    nd_vld_d   = nd_vld_q;
    holder_d   = holder_q;
    running_d  = running_q;
    nd_we      = 1'b0;
    res_status = StatusNone;
    res_lat    = '0;

    if (fire) begin
      unique case (item_q.op)
        OpFlags: begin
          if (a_ok) begin
            hd_d[a_idx]  = item_q.has_data;
            off_d[a_idx] = item_q.is_off;
          end
        end
        OpDist: begin
          if (a_ok && b_ok && link && hd_b && (item_q.distance < nd_a)) begin
            nd_we           = 1'b1;
            nd_vld_d[a_idx] = 1'b1;
          end
        end
        OpStart: begin
          if (!a_ok || off_a || hd_a) begin
            res_status = StatusRejected;
            running_d  = 1'b0;
          end else begin
            rm_d        = '0;
            rm_d[a_idx] = 1'b1;
            holder_d    = a_idx;
            running_d   = 1'b1;
          end
        end
        OpContact: begin
          if (ct_go) begin
            if (mode_q == ModeEpidemic) begin
              if (e_en1) begin
                rm_d[a_idx] = 1'b1;
              end
              if (!e_hit1 && e_en2) begin
                rm_d[b_idx] = 1'b1;
              end
              if (e_hit1 || e_hit2) begin
                res_status = StatusReached;
              end
            end else begin
              holder_d = g_h1;
              if (!g_hit1 && g_en2) begin
                holder_d = g_h2;
              end
              if (g_hit1 || g_hit2) begin
                res_status = StatusReached;
              end
            end
            if (res_status == StatusReached) begin
              res_lat   = item_q.contact_time - win_start_q;
              running_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q      <= '0;
      off_q     <= '0;
      rm_q      <= '0;
      nd_vld_q  <= '0;
      holder_q  <= '0;
      running_q <= 1'b0;
    end else begin
      hd_q      <= hd_d;
      off_q     <= off_d;
      rm_q      <= rm_d;
      nd_vld_q  <= nd_vld_d;
      holder_q  <= holder_d;
      running_q <= running_d;
    end
  end

  // Result register.
  status_e          out_status_q;
  logic [TimeW-1:0] out_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= res_status;
      out_lat_q    <= res_lat;
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.status  = out_status_q;
  assign out_ch.latency = out_lat_q;

  // Checks.
  a_latency_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_status_q != StatusReached) |-> (out_lat_q == '0))
    else $error("latency is nonzero on a result that did not reach data");

  a_stop_on_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_status == StatusReached) |=> !running_q)
    else $error("request still running after data was reached");

  a_run_has_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (rm_q != '0))
    else $error("running request without any reached node");

  a_holder_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (32'(holder_q) < NODES))
    else $error("request holder outside the node range");

endmodule

// ===== src/ctrf_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module ctrf_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== dv/contact_trace_request_forwarding_core_test.sv =====
// Self-checking testbench of the contact trace request forwarding core.
`timescale 1ns / 100ps

// The bench replays node flag, distance, start and contact events into the
// core and checks every result transfer against the result written in the
// trace or a forwarding predictor kept in step with the accepted transfers.
// A short directed trace comes first, followed by random phases. Each phase
// writes all three configuration registers while the core is idle, then
// plays well-formed request sessions on small node pools amid random noise.
module contact_trace_request_forwarding_core_test;
  import ctrf_pkg::*;

  localparam int          Nodes       = 64;
  localparam int          RandomItems = 1900;
  localparam int          HoldCycles  = 300;
  localparam int          SettleCycles = 4;
  localparam int unsigned CycleLimit  = 250000;

  // What one line of the stimulus trace asks the driver to do.
  typedef enum logic [1:0] {
    RowEvent,
    RowConfig,
    RowDrain,
    RowHoldoff
  } row_kind_e;

  // Window shapes used by the random phases, the extremes among them.
  typedef enum int {
    WinFull,
    WinLow,
    WinEmpty,
    WinTop,
    WinAny,
    WinShort
  } win_shape_e;

  typedef struct {
    row_kind_e        kind;
    in_item_t         ev;
    cfg_idx_e         idx;
    logic [TimeW-1:0] wdata;
    bit               typed;
    status_e          status;
    logic [TimeW-1:0] latency;
  } trace_row_t;

  typedef struct packed {
    status_e          status;
    logic [TimeW-1:0] latency;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TimeW-1:0]   cfg_wdata_i;

  ctrf_in_if  in_ch ();
  ctrf_out_if out_ch ();

  contact_trace_request_forwarding_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Stimulus trace, expected outcomes in transfer order, and bookkeeping.
  trace_row_t  trace_q [$];
  outcome_t    pending_outcomes [$];
  int          event_rows;
  int          errors;
  bit          hold_request;
  int unsigned cycle_count;

  // Predictor copy of the forwarding state and of the configuration.
  logic [Nodes-1:0] data_q;
  logic [Nodes-1:0] off_q;
  logic [Nodes-1:0] reached_q;
  logic [DistW-1:0] nearest_q [Nodes];
  logic [NodeW-1:0] holder_q;
  logic             running_q;
  mode_e            mode_q;
  logic [TimeW-1:0] win_start_q;
  logic [TimeW-1:0] win_end_q;

  always #10 clk_i = ~clk_i;

  // One direction of a contact, from src to dst. It returns one when the
  // request reaches a node that holds the data.
  function automatic bit pass_step(logic [NodeW-1:0] src, logic [NodeW-1:0] dst);
    if (off_q[src] || off_q[dst]) return 1'b0;
    if (mode_q == ModeEpidemic) begin
      // Flooding: a reached sender marks the receiver as reached.
      if (!reached_q[src]) return 1'b0;
      reached_q[dst] = 1'b1;
      return data_q[dst];
    end
    // Greedy: only the current holder hands over, and only downhill.
    if (holder_q != src) return 1'b0;
    if (nearest_q[dst] < nearest_q[src]) holder_q = dst;
    return data_q[holder_q];
  endfunction

  // Applies one accepted event to the predictor state and works out the
  // result that the core must give for it.
  function automatic void forward_result(input in_item_t e, output status_e st,
                                         output logic [TimeW-1:0] lat);
    st  = StatusNone;
    lat = '0;
    case (e.op)
      OpFlags: begin
        data_q[e.node_a] = e.has_data;
        off_q[e.node_a]  = e.is_off;
      end
      OpDist: begin
        // Only a live path toward a live data holder can shorten the distance.
        if (!off_q[e.node_a] && !off_q[e.node_b] && data_q[e.node_b] &&
            e.distance < nearest_q[e.node_a]) begin
          nearest_q[e.node_a] = e.distance;
        end
      end
      OpStart: begin
        if (off_q[e.node_a] || data_q[e.node_a]) begin
          st        = StatusRejected;
          running_q = 1'b0;
        end else begin
          reached_q           = '0;
          reached_q[e.node_a] = 1'b1;
          holder_q            = e.node_a;
          running_q           = 1'b1;
        end
      end
      default: begin
        // A contact counts only during a run and inside the window. The
        // second node talks first; short-circuit skips the other direction.
        if (running_q && e.contact_time >= win_start_q && e.contact_time < win_end_q) begin
          if (pass_step(e.node_b, e.node_a) || pass_step(e.node_a, e.node_b)) begin
            st        = StatusReached;
            lat       = e.contact_time - win_start_q;
            running_q = 1'b0;
          end
        end
      end
    endcase
  endfunction

  function automatic in_item_t ev(op_e op, logic [NodeW-1:0] a, logic [NodeW-1:0] b,
                                  logic hd, logic off, logic [DistW-1:0] d,
                                  logic [TimeW-1:0] t);
    in_item_t e;
    e.op           = op;
    e.node_a       = a;
    e.node_b       = b;
    e.has_data     = hd;
    e.is_off       = off;
    e.distance     = d;
    e.contact_time = t;
    return e;
  endfunction

  // An event checked against the predictor.
  function automatic void add_ev(in_item_t e);
    trace_row_t r;
    r.kind    = RowEvent;
    r.ev      = e;
    r.idx     = CfgForwardMode;
    r.wdata   = '0;
    r.typed   = 1'b0;
    r.status  = StatusNone;
    r.latency = '0;
    trace_q.push_back(r);
    event_rows++;
  endfunction

  // An event whose result is written out in the trace.
  function automatic void add_chk(in_item_t e, status_e st, logic [TimeW-1:0] lat);
    trace_row_t r;
    r.kind    = RowEvent;
    r.ev      = e;
    r.idx     = CfgForwardMode;
    r.wdata   = '0;
    r.typed   = 1'b1;
    r.status  = st;
    r.latency = lat;
    trace_q.push_back(r);
    event_rows++;
  endfunction

  function automatic void add_ctl(row_kind_e kind, cfg_idx_e idx, logic [TimeW-1:0] v);
    trace_row_t r;
    r.kind    = kind;
    r.ev      = '0;
    r.idx     = idx;
    r.wdata   = v;
    r.typed   = 1'b0;
    r.status  = StatusNone;
    r.latency = '0;
    trace_q.push_back(r);
  endfunction

  // One request session on a small pool of distinct nodes: flags first, then
  // distance entries, a start, and a time-ordered run of contacts.
  function automatic void add_session(logic [TimeW-1:0] ws);
    logic [NodeW-1:0] pool [8];
    logic [TimeW-1:0] t;
    logic [DistW-1:0] d;
    int k;
    int base;
    int stride;
    k      = $urandom_range(3, 8);
    base   = $urandom_range(0, Nodes - 1);
    stride = 2 * $urandom_range(0, 31) + 1;
    for (int i = 0; i < k; i++) pool[i] = NodeW'(base + i * stride);
    // The requester is live and empty; the last pool node holds the data.
    add_ev(ev(OpFlags, pool[0], NodeW'($urandom), 1'b0, 1'b0, DistW'($urandom), $urandom));
    for (int i = 1; i < k; i++) begin
      add_ev(ev(OpFlags, pool[i], NodeW'($urandom),
                (i == k - 1) || ($urandom_range(0, 3) == 0),
                (i != k - 1) && ($urandom_range(0, 7) == 0),
                DistW'($urandom), $urandom));
    end
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 9))
        0:       d = DistUnreach;
        1:       d = DistW'($urandom_range(0, 15));
        default: d = DistW'($urandom_range(256, 65535));
      endcase
      add_ev(ev(OpDist, pool[i], pool[$urandom_range(0, k - 1)], 1'($urandom),
                1'($urandom), d, $urandom));
    end
    add_ev(ev(OpDist, pool[k - 1], pool[k - 1], 1'($urandom), 1'($urandom),
              DistW'($urandom_range(0, 255)), $urandom));
    // Now and then the request starts at a node that may be rejected.
    add_ev(ev(OpStart, ($urandom_range(0, 9) == 0) ? pool[$urandom_range(0, k - 1)] : pool[0],
              NodeW'($urandom), 1'($urandom), 1'($urandom), DistW'($urandom), $urandom));
    t = ws + $urandom_range(0, 20);
    repeat ($urandom_range(4, 24)) begin
      if ($urandom_range(0, 19) == 0) begin
        // A flag change in the middle of a run takes effect at once.
        add_ev(ev(OpFlags, pool[$urandom_range(1, k - 1)], NodeW'($urandom),
                  1'($urandom), 1'($urandom), DistW'($urandom), $urandom));
      end
      add_ev(ev(OpContact, pool[$urandom_range(0, k - 1)], pool[$urandom_range(0, k - 1)],
                1'($urandom), 1'($urandom), DistW'($urandom), t));
      t = t + $urandom_range(0, 3);
    end
  endfunction

  function automatic void build_trace();
    win_shape_e       shape;
    logic [TimeW-1:0] ws;
    logic [TimeW-1:0] we;
    int               phase;
    int               target;

    // Directed trace, reset configuration: epidemic, full window.
    add_chk(ev(OpContact, 6'd0, 6'd63, 1'b0, 1'b0, 16'd0, 32'd0), StatusNone, 32'd0);
    add_chk(ev(OpFlags, 6'd63, 6'd0, 1'b1, 1'b0, 16'd0, 32'd0), StatusNone, 32'd0);
    add_chk(ev(OpFlags, 6'd62, 6'd63, 1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF), StatusNone, 32'd0);
    add_ev(ev(OpDist, 6'd0, 6'd63, 1'b0, 1'b0, 16'hFFFF, 32'd0));
    add_ev(ev(OpDist, 6'd0, 6'd63, 1'b0, 1'b0, 16'd1, 32'd0));
    add_ev(ev(OpDist, 6'd63, 6'd63, 1'b0, 1'b0, 16'd0, 32'd0));
    add_chk(ev(OpStart, 6'd63, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0), StatusRejected, 32'd0);
    add_chk(ev(OpStart, 6'd62, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0), StatusRejected, 32'd0);
    add_ev(ev(OpStart, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    add_ev(ev(OpContact, 6'd1, 6'd0, 1'b0, 1'b0, 16'd0, 32'd5));
    add_chk(ev(OpContact, 6'd62, 6'd1, 1'b0, 1'b0, 16'd0, 32'd6), StatusNone, 32'd0);
    add_chk(ev(OpContact, 6'd63, 6'd1, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFFE),
            StatusReached, 32'hFFFF_FFFE);
    add_chk(ev(OpContact, 6'd63, 6'd1, 1'b0, 1'b0, 16'd0, 32'd7), StatusNone, 32'd0);
    add_ev(ev(OpStart, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    // The window end itself is outside the window.
    add_chk(ev(OpContact, 6'd0, 6'd63, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFFF), StatusNone, 32'd0);
    add_chk(ev(OpContact, 6'd63, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0), StatusReached, 32'd0);
    // Greedy handover inside the window [100, 200).
    add_ctl(RowConfig, CfgForwardMode, 32'(ModeGreedy));
    add_ctl(RowConfig, CfgWindowStart, 32'd100);
    add_ctl(RowConfig, CfgWindowEnd, 32'd200);
    add_ev(ev(OpDist, 6'd5, 6'd63, 1'b0, 1'b0, 16'd10, 32'd0));
    add_ev(ev(OpStart, 6'd5, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    add_chk(ev(OpContact, 6'd5, 6'd0, 1'b0, 1'b0, 16'd0, 32'd99), StatusNone, 32'd0);
    add_ev(ev(OpContact, 6'd0, 6'd5, 1'b0, 1'b0, 16'd0, 32'd150));
    add_ev(ev(OpContact, 6'd0, 6'd63, 1'b0, 1'b0, 16'd0, 32'd199));
    add_ev(ev(OpStart, 6'd5, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    add_chk(ev(OpContact, 6'd0, 6'd5, 1'b0, 1'b0, 16'd0, 32'd200), StatusNone, 32'd0);
    // An inverted window ignores every contact.
    add_ctl(RowConfig, CfgWindowStart, 32'hFFFF_FFFF);
    add_ctl(RowConfig, CfgWindowEnd, 32'd0);
    add_ev(ev(OpStart, 6'd0, 6'd0, 1'b0, 1'b0, 16'd0, 32'd0));
    add_chk(ev(OpContact, 6'd63, 6'd0, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFFF), StatusNone, 32'd0);

    // Random phases until the item count is reached.
    target = event_rows + RandomItems;
    phase  = 0;
    while (event_rows < target) begin
      shape = (phase < 6) ? win_shape_e'(phase) : win_shape_e'($urandom_range(0, 5));
      case (shape)
        WinFull:  begin ws = '0; we = '1; end
        WinLow:   begin ws = $urandom_range(0, 1000); we = ws + $urandom_range(20, 200); end
        WinEmpty: begin ws = $urandom; we = ws; end
        WinTop:   begin ws = 32'hFFFF_FF00; we = '1; end
        WinAny:   begin ws = $urandom; we = $urandom; end
        default:  begin ws = '0; we = $urandom_range(5, 60); end
      endcase
      add_ctl(RowConfig, CfgForwardMode, 32'($urandom_range(0, 1)));
      add_ctl(RowConfig, CfgWindowStart, ws);
      add_ctl(RowConfig, CfgWindowEnd, we);
      if (phase == 1) add_ctl(RowHoldoff, CfgForwardMode, '0);
      repeat ($urandom_range(6, 14)) begin
        if (event_rows < target) begin
          if (phase == 3 || $urandom_range(0, 14) == 0) add_ctl(RowDrain, CfgForwardMode, '0);
          if ($urandom_range(0, 9) < 7) begin
            add_session(ws);
          end else begin
            repeat ($urandom_range(1, 6)) begin
              add_ev(ev(op_e'($urandom_range(0, 3)), NodeW'($urandom), NodeW'($urandom),
                        1'($urandom), 1'($urandom), DistW'($urandom), $urandom));
            end
          end
        end
      end
      phase++;
    end
  endfunction

  // Sender: walks the trace, in bursts of random length with random gaps.
  initial begin
    trace_row_t       r;
    status_e          st;
    logic [TimeW-1:0] lat;
    int               burst_left;
    int               gap;

    clk_i = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OpFlags;
    in_ch.node_a <= '0;
    in_ch.node_b <= '0;
    in_ch.has_data <= 1'b0;
    in_ch.is_off <= 1'b0;
    in_ch.distance <= '0;
    in_ch.contact_time <= '0;
    out_ch.ready <= 1'b0;

    data_q      = '0;
    off_q       = '0;
    reached_q   = '0;
    holder_q    = '0;
    running_q   = 1'b0;
    mode_q      = ModeEpidemic;
    win_start_q = '0;
    win_end_q   = '1;
    for (int i = 0; i < Nodes; i++) nearest_q[i] = DistUnreach;
    event_rows   = 0;
    errors       = 0;
    hold_request = 1'b0;
    burst_left   = 0;
    build_trace();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (trace_q.size() != 0) begin
      r = trace_q.pop_front();
      case (r.kind)
        RowConfig: begin
          // Registers change only with nothing in flight.
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
          while (pending_outcomes.size() != 0) @(posedge clk_i);
          repeat (SettleCycles) @(negedge clk_i);
          cfg_we_i <= 1'b1;
          cfg_idx_i <= r.idx;
          cfg_wdata_i <= r.wdata;
          case (r.idx)
            CfgForwardMode: mode_q = mode_e'(r.wdata[0]);
            CfgWindowStart: win_start_q = r.wdata;
            default:        win_end_q = r.wdata;
          endcase
          @(negedge clk_i);
          cfg_we_i <= 1'b0;
        end
        RowDrain: begin
          // Pause the sender until every expected result has come out.
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
          while (pending_outcomes.size() != 0) @(posedge clk_i);
        end
        RowHoldoff: begin
          hold_request = 1'b1;
        end
        default: begin
          if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
              @(negedge clk_i);
              in_ch.valid <= 1'b0;
              repeat (gap - 1) @(negedge clk_i);
            end
          end
          burst_left--;
          @(negedge clk_i);
          in_ch.valid <= 1'b1;
          in_ch.op <= r.ev.op;
          in_ch.node_a <= r.ev.node_a;
          in_ch.node_b <= r.ev.node_b;
          in_ch.has_data <= r.ev.has_data;
          in_ch.is_off <= r.ev.is_off;
          in_ch.distance <= r.ev.distance;
          in_ch.contact_time <= r.ev.contact_time;
          @(posedge clk_i);
          while (!in_ch.ready) @(posedge clk_i);
          // The transfer took place at this edge: predict its result.
          forward_result(r.ev, st, lat);
          if (r.typed) begin
            pending_outcomes.push_back('{status: r.status, latency: r.latency});
          end else begin
            pending_outcomes.push_back('{status: st, latency: lat});
          end
        end
      endcase
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    // Give any stray result time to show up.
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: switches between random stall patterns, and once holds off for
  // a long stretch so the core fills up and stalls its input.
  initial begin
    int pattern;
    int step;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end
      pattern = $urandom_range(0, 3);
      step    = 0;
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk_i);
        case (pattern)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((step % 5) != 0);
        endcase
        step++;
      end
    end
  end

  // Result checker: every result transfer is matched with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d latency %0d",
                 $time, out_ch.status, out_ch.latency);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_ch.status);
          errors++;
        end
        if (out_ch.latency !== want.latency) begin
          $display("%0t: latency mismatch, expected %0d, actual %0d",
                   $time, want.latency, out_ch.latency);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

// ===== files.f =====
src/ctrf_pkg.sv
src/ctrf_in_if.sv
src/ctrf_out_if.sv
src/ctrf_ram.sv
src/contact_trace_request_forwarding_core.sv
dv/contact_trace_request_forwarding_core_test.sv
